### src/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants for the length-prefixed frame decoder: phase
// codes, result kinds, status codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfd_pkg;

	// frame layout
	localparam int PARAM_SLOTS  = 8;
	localparam int HEADER_BYTES = 20;
	localparam int HDR_WORDS    = 5;
	localparam int PLEN_WORD    = 4;

	// register reset values
	localparam logic        COPY_ENABLE_RESET = 1'b1;
	localparam logic [31:0] CAPACITY_RESET    = 32'd4096;

	// configuration register indexes
	localparam logic CFG_COPY_ENABLE      = 1'b0;
	localparam logic CFG_PAYLOAD_CAPACITY = 1'b1;

	// result queue geometry
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_HEADER,
		PH_TABLE,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_LENGTH = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TRUNC   = 2'd1,
		ST_NOSPACE = 2'd2
	} status_t;

	// one result item as seen on the output channel
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [3:0]  param_index;
		logic [31:0] param_length;
		status_t     status;
		logic [31:0] session_word;
		logic [31:0] sequence_word;
		logic [31:0] command_word;
		logic [31:0] ack_word;
		logic [31:0] payload_length;
		logic [31:0] param_total;
	} result_t;

	// up to two results produced by one accepted byte, in order
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

`default_nettype wire

### src/lpfd_parse.sv
// ----------------------------------------------------------------------------
// lpfd_parse
// Frame parser: assembles little-endian words, checks the header and the
// length table, and produces up to two result items per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_parse #(
	parameter int PARAM_SLOTS = lpfd_pkg::PARAM_SLOTS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  in_last,
	input  wire logic                  copy_enable,
	input  wire logic [31:0]           payload_capacity,
	output lpfd_pkg::push_t            push
);

	localparam int CNT_MAX = (PARAM_SLOTS > lpfd_pkg::HDR_WORDS) ?
		PARAM_SLOTS : lpfd_pkg::HDR_WORDS;
	localparam int CNT_W = $clog2(CNT_MAX + 1);
	localparam logic [31:0] TABLE_BYTES = 32'(4 * PARAM_SLOTS);
	localparam logic [31:0] HDR_BYTES   = 32'(lpfd_pkg::HEADER_BYTES);

	// parser state
	lpfd_pkg::phase_t  phase_q, phase_n;
	logic [1:0]        pos_q, pos_n;
	logic [31:0]       shift_q, shift_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic [31:0]       prefix_len_q, prefix_len_n;
	logic [31:0]       hdr_q [lpfd_pkg::HDR_WORDS];
	logic [31:0]       hdr_n [lpfd_pkg::HDR_WORDS];
	logic [31:0]       sum_q, sum_n;
	logic [31:0]       remain_q, remain_n;
	lpfd_pkg::status_t pend_q, pend_n;

	// per-byte decode
	logic [31:0]      word;
	logic             word_done;
	logic [31:0]      sum_add;
	logic             frame_ok;
	logic             plen_short;
	logic             table_ok;
	logic [31:0]      remain_dec;
	logic             pass_byte;
	logic [CNT_W-1:0] cnt_inc;
	logic             hdr_last;
	logic             slot_last;

	// transition flags
	logic              len_emit;
	logic              byte_emit;
	logic              stat_emit;
	lpfd_pkg::status_t stat_code;
	logic              stat_any;
	lpfd_pkg::status_t stat_final;

	assign word       = {in_byte, shift_q[31:8]};
	assign word_done  = (pos_q == 2'd3);
	assign sum_add    = sum_q + word;
	assign frame_ok   = (prefix_len_q == HDR_BYTES + word);
	assign plen_short = (word < TABLE_BYTES);
	assign table_ok   = ({1'b0, hdr_q[lpfd_pkg::PLEN_WORD]} ==
		{1'b0, TABLE_BYTES} + {1'b0, sum_add});
	assign remain_dec = (remain_q != 32'd0) ? remain_q - 32'd1 : 32'd0;
	assign pass_byte  = copy_enable && (pend_q != lpfd_pkg::ST_NOSPACE);
	assign cnt_inc    = cnt_q + 1'b1;
	assign hdr_last   = (cnt_inc == CNT_W'(lpfd_pkg::HDR_WORDS));
	assign slot_last  = (cnt_inc == CNT_W'(PARAM_SLOTS));

	// next state
	always_comb begin
		phase_n      = phase_q;
		pos_n        = pos_q;
		shift_n      = shift_q;
		cnt_n        = cnt_q;
		prefix_len_n = prefix_len_q;
		hdr_n        = hdr_q;
		sum_n        = sum_q;
		remain_n     = remain_q;
		pend_n       = pend_q;
		len_emit     = 1'b0;
		byte_emit    = 1'b0;
		stat_emit    = 1'b0;
		stat_code    = lpfd_pkg::ST_OK;
		case (phase_q)
			lpfd_pkg::PH_PREFIX, lpfd_pkg::PH_HEADER, lpfd_pkg::PH_TABLE: begin
				shift_n = word;
				if (word_done) begin
					pos_n = 2'd0;
					if (phase_q == lpfd_pkg::PH_PREFIX) begin
						prefix_len_n = word;
						cnt_n        = '0;
						phase_n      = lpfd_pkg::PH_HEADER;
					end else if (phase_q == lpfd_pkg::PH_HEADER) begin
						for (int i = 0; i < lpfd_pkg::HDR_WORDS; i++) begin
							if (cnt_q == CNT_W'(i))
								hdr_n[i] = word;
						end
						cnt_n = cnt_inc;
						if (hdr_last) begin
							if (!frame_ok || plen_short) begin
								stat_emit = 1'b1;
								stat_code = lpfd_pkg::ST_TRUNC;
								phase_n   = lpfd_pkg::PH_DONE;
							end else begin
								phase_n = lpfd_pkg::PH_TABLE;
								cnt_n   = '0;
								sum_n   = 32'd0;
							end
						end
					end else begin
						len_emit = 1'b1;
						sum_n    = sum_add;
						cnt_n    = cnt_inc;
						if (slot_last) begin
							if (!table_ok) begin
								stat_emit = 1'b1;
								stat_code = lpfd_pkg::ST_TRUNC;
								phase_n   = lpfd_pkg::PH_DONE;
							end else if (sum_add == 32'd0) begin
								stat_emit = 1'b1;
								stat_code = lpfd_pkg::ST_OK;
								phase_n   = lpfd_pkg::PH_DONE;
							end else begin
								pend_n   = (copy_enable && (payload_capacity < sum_add)) ?
									lpfd_pkg::ST_NOSPACE : lpfd_pkg::ST_OK;
								remain_n = sum_add;
								phase_n  = lpfd_pkg::PH_DATA;
							end
						end
					end
				end else begin
					pos_n = pos_q + 2'd1;
				end
			end
			lpfd_pkg::PH_DATA: begin
				byte_emit = pass_byte;
				remain_n  = remain_dec;
				if (remain_dec == 32'd0) begin
					stat_emit = 1'b1;
					stat_code = pend_q;
					phase_n   = lpfd_pkg::PH_DONE;
				end
			end
			default: begin
				// trailing bytes after the status are dropped
			end
		endcase
	end

	// buffer end before any status forces a truncated status
	assign stat_any   = stat_emit || (in_last && (phase_n != lpfd_pkg::PH_DONE));
	assign stat_final = stat_emit ? stat_code : lpfd_pkg::ST_TRUNC;

	// result items
	always_comb begin
		lpfd_pkg::result_t item_a;
		lpfd_pkg::result_t item_s;
		item_a = '0;
		item_s = '0;
		if (len_emit) begin
			item_a.kind         = lpfd_pkg::KIND_LENGTH;
			item_a.param_index  = 4'(cnt_q);
			item_a.param_length = word;
		end else begin
			item_a.kind      = lpfd_pkg::KIND_DATA;
			item_a.data_byte = in_byte;
		end
		item_s.kind           = lpfd_pkg::KIND_STATUS;
		item_s.status         = stat_final;
		item_s.session_word   = hdr_n[0];
		item_s.sequence_word  = hdr_n[1];
		item_s.command_word   = hdr_n[2];
		item_s.ack_word       = hdr_n[3];
		item_s.payload_length = hdr_n[4];
		item_s.param_total    = sum_n;
		push.second = item_s;
		if (len_emit || byte_emit) begin
			push.first = item_a;
			push.count = fire ? (stat_any ? 2'd2 : 2'd1) : 2'd0;
		end else begin
			push.first = item_s;
			push.count = (fire && stat_any) ? 2'd1 : 2'd0;
		end
	end

	// state registers, rearmed at the buffer's last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= lpfd_pkg::PH_PREFIX;
			pos_q        <= 2'd0;
			shift_q      <= 32'd0;
			cnt_q        <= '0;
			prefix_len_q <= 32'd0;
			for (int i = 0; i < lpfd_pkg::HDR_WORDS; i++)
				hdr_q[i] <= 32'd0;
			sum_q        <= 32'd0;
			remain_q     <= 32'd0;
			pend_q       <= lpfd_pkg::ST_OK;
		end else if (fire) begin
			if (in_last) begin
				phase_q      <= lpfd_pkg::PH_PREFIX;
				pos_q        <= 2'd0;
				shift_q      <= 32'd0;
				cnt_q        <= '0;
				prefix_len_q <= 32'd0;
				for (int i = 0; i < lpfd_pkg::HDR_WORDS; i++)
					hdr_q[i] <= 32'd0;
				sum_q        <= 32'd0;
				remain_q     <= 32'd0;
				pend_q       <= lpfd_pkg::ST_OK;
			end else begin
				phase_q      <= phase_n;
				pos_q        <= pos_n;
				shift_q      <= shift_n;
				cnt_q        <= cnt_n;
				prefix_len_q <= prefix_len_n;
				hdr_q        <= hdr_n;
				sum_q        <= sum_n;
				remain_q     <= remain_n;
				pend_q       <= pend_n;
			end
		end
	end

endmodule

`default_nettype wire

### src/lpfd_outq.sv
// ----------------------------------------------------------------------------
// lpfd_outq
// Result queue: takes up to two results per cycle from the parser and
// presents one per cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lpfd_pkg::push_t   push,
	input  wire logic              pop,
	output logic                   room,
	output logic                   valid,
	output lpfd_pkg::result_t      head
);

	localparam int PTR_W = lpfd_pkg::QPTR_W;
	localparam int CNT_W = lpfd_pkg::QPTR_W + 1;

	lpfd_pkg::result_t entry_q [lpfd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;

	// space for a two-result request
	assign room  = (cnt_q <= CNT_W'(lpfd_pkg::QUEUE_DEPTH - 2));
	assign valid = (cnt_q != '0);
	assign head  = entry_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			entry_q[wr_q] <= push.first;
		if (push.count == 2'd2)
			entry_q[wr_q + 1'b1] <= push.second;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.count);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

### src/length_prefixed_frame_decoder_unit.sv
// Path: each result is written into the result queue when its byte is accepted
// and is offered from the queue head. Throughput: one byte per cycle while the
// queue has room; a byte with two results (length or data plus status) stores both.
// The four-entry result queue sets the stall point: input ready drops above two.
// Reset: arst_n clears the parser and queue; copy_enable = 1, capacity = 4096.
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder_unit
// Top level: configuration registers, frame parser and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_decoder_unit #(
	parameter int PARAM_SLOTS = lpfd_pkg::PARAM_SLOTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_last,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       data_byte,
	output logic [3:0]       param_index,
	output logic [31:0]      param_length,
	output logic [1:0]       status,
	output logic [31:0]      session_word,
	output logic [31:0]      sequence_word,
	output logic [31:0]      command_word,
	output logic [31:0]      ack_word,
	output logic [31:0]      payload_length,
	output logic [31:0]      param_total,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic              copy_enable_q;
	logic [31:0]       capacity_q;
	logic              fire;
	logic              room;
	lpfd_pkg::push_t   push;
	lpfd_pkg::result_t head;

	assign cfg_ready = 1'b1;
	assign in_ready  = room;
	assign fire      = in_valid && room;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_enable_q <= lpfd_pkg::COPY_ENABLE_RESET;
			capacity_q    <= lpfd_pkg::CAPACITY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				lpfd_pkg::CFG_COPY_ENABLE:      copy_enable_q <= cfg_data[0];
				lpfd_pkg::CFG_PAYLOAD_CAPACITY: capacity_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// frame parser
	lpfd_parse #(
		.PARAM_SLOTS (PARAM_SLOTS)
	) u_parse (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.in_byte          (in_byte),
		.in_last          (in_last),
		.copy_enable      (copy_enable_q),
		.payload_capacity (capacity_q),
		.push             (push)
	);

	// result queue
	lpfd_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (out_valid && out_ready),
		.room   (room),
		.valid  (out_valid),
		.head   (head)
	);

	// output fields
	assign kind           = head.kind;
	assign data_byte      = head.data_byte;
	assign param_index    = head.param_index;
	assign param_length   = head.param_length;
	assign status         = head.status;
	assign session_word   = head.session_word;
	assign sequence_word  = head.sequence_word;
	assign command_word   = head.command_word;
	assign ack_word       = head.ack_word;
	assign payload_length = head.payload_length;
	assign param_total    = head.param_total;

endmodule

`default_nettype wire

### verif/length_prefixed_frame_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder_unit_tb
// Self-checking bench for the frame decoder. Buffers of well-formed and
// damaged frames are fed byte by byte under random input and output stalls.
// A frame result board decodes every accepted byte on its own and checks each
// result leaving the block against the oldest result it still has due.
// ----------------------------------------------------------------------------
`default_nettype none

// decodes accepted bytes and holds the results still due from the block
class frame_board_t;
	localparam int TABLE_BYTES = 4 * lpfd_pkg::PARAM_SLOTS;

	bit          copy_en;
	logic [31:0] capacity;

	lpfd_pkg::phase_t  phase;
	int unsigned       byte_pos;
	logic [31:0]       shift;
	int unsigned       word_cnt;
	logic [31:0]       prefix_len;
	logic [31:0]       hdr_words [lpfd_pkg::HDR_WORDS];
	logic [31:0]       len_sum;
	logic [31:0]       remaining;
	lpfd_pkg::status_t held_status;

	lpfd_pkg::result_t results_due [$];
	int unsigned       failures;

	function new();
		copy_en = lpfd_pkg::COPY_ENABLE_RESET;
		capacity = lpfd_pkg::CAPACITY_RESET;
		failures = 0;
		rearm();
	endfunction

	function void rearm();
		phase = lpfd_pkg::PH_PREFIX;
		byte_pos = 0;
		shift = '0;
		word_cnt = 0;
		prefix_len = '0;
		foreach (hdr_words[i]) hdr_words[i] = '0;
		len_sum = '0;
		remaining = '0;
		held_status = lpfd_pkg::ST_OK;
	endfunction

	function void write_register(logic idx, logic [31:0] value);
		if (idx == lpfd_pkg::CFG_COPY_ENABLE) begin
			copy_en = value[0];
		end else begin
			capacity = value;
		end
	endfunction

	// final status item carrying the header words and the length sum
	function void push_status(lpfd_pkg::status_t code);
		lpfd_pkg::result_t r;
		r = '0;
		r.kind = lpfd_pkg::KIND_STATUS;
		r.status = code;
		r.session_word = hdr_words[0];
		r.sequence_word = hdr_words[1];
		r.command_word = hdr_words[2];
		r.ack_word = hdr_words[3];
		r.payload_length = hdr_words[lpfd_pkg::PLEN_WORD];
		r.param_total = len_sum;
		results_due.push_back(r);
		phase = lpfd_pkg::PH_DONE;
	endfunction

	// work out the results caused by one accepted byte
	function void decode_byte(logic [7:0] b, logic last);
		lpfd_pkg::result_t r;
		logic [31:0]       w;
		logic [31:0]       plen;
		if (phase == lpfd_pkg::PH_PREFIX || phase == lpfd_pkg::PH_HEADER
				|| phase == lpfd_pkg::PH_TABLE) begin
			shift = {b, shift[31:8]};
			if (byte_pos >= 3) begin
				w = shift;
				byte_pos = 0;
				case (phase)
					lpfd_pkg::PH_PREFIX: begin
						prefix_len = w;
						word_cnt = 0;
						phase = lpfd_pkg::PH_HEADER;
					end
					lpfd_pkg::PH_HEADER: begin
						if (word_cnt < lpfd_pkg::HDR_WORDS) hdr_words[word_cnt] = w;
						word_cnt++;
						if (word_cnt >= lpfd_pkg::HDR_WORDS) begin
							plen = hdr_words[lpfd_pkg::PLEN_WORD];
							if (prefix_len != 32'(lpfd_pkg::HEADER_BYTES) + plen) begin
								push_status(lpfd_pkg::ST_TRUNC);
							end else if (plen < 32'(TABLE_BYTES)) begin
								push_status(lpfd_pkg::ST_TRUNC);
							end else begin
								phase = lpfd_pkg::PH_TABLE;
								word_cnt = 0;
								len_sum = '0;
							end
						end
					end
					default: begin
						r = '0;
						r.kind = lpfd_pkg::KIND_LENGTH;
						r.param_index = 4'(word_cnt);
						r.param_length = w;
						results_due.push_back(r);
						len_sum = len_sum + w;
						word_cnt++;
						if (word_cnt >= lpfd_pkg::PARAM_SLOTS) begin
							// table and sum are compared without wrapping the addition
							if (64'(hdr_words[lpfd_pkg::PLEN_WORD]) !=
									64'(TABLE_BYTES) + 64'(len_sum)) begin
								push_status(lpfd_pkg::ST_TRUNC);
							end else if (len_sum == 0) begin
								push_status(lpfd_pkg::ST_OK);
							end else begin
								held_status = (copy_en && capacity < len_sum) ?
									lpfd_pkg::ST_NOSPACE : lpfd_pkg::ST_OK;
								remaining = len_sum;
								phase = lpfd_pkg::PH_DATA;
							end
						end
					end
				endcase
			end else begin
				byte_pos++;
			end
		end else if (phase == lpfd_pkg::PH_DATA) begin
			// copy enable is looked at per data byte
			if (copy_en && held_status != lpfd_pkg::ST_NOSPACE) begin
				r = '0;
				r.kind = lpfd_pkg::KIND_DATA;
				r.data_byte = b;
				results_due.push_back(r);
			end
			if (remaining > 0) remaining--;
			if (remaining == 0) push_status(held_status);
		end

		// buffer end: truncated unless a status was given, then rearm
		if (last) begin
			if (phase != lpfd_pkg::PH_DONE) push_status(lpfd_pkg::ST_TRUNC);
			rearm();
		end
	endfunction

	function string show(lpfd_pkg::result_t r);
		return $sformatf({"kind=%0d byte=%02h idx=%0d len=%08h st=%0d ",
			"hdr=%08h %08h %08h %08h %08h sum=%08h"},
			r.kind, r.data_byte, r.param_index, r.param_length, r.status, r.session_word,
			r.sequence_word, r.command_word, r.ack_word, r.payload_length, r.param_total);
	endfunction

	// compare one result from the block with the oldest one due
	function void check_result(lpfd_pkg::result_t got);
		lpfd_pkg::result_t want;
		if (results_due.size() == 0) begin
			failures++;
			if (failures <= 10) $display("unexpected result: %s", show(got));
			return;
		end
		want = results_due.pop_front();
		if (got !== want) begin
			failures++;
			if (failures <= 10) begin
				$display("result mismatch");
				$display("  expected: %s", show(want));
				$display("  actual:   %s", show(got));
			end
		end
	endfunction

	function int unsigned waiting();
		return results_due.size();
	endfunction

	// results still due at the end count as failures
	function int unsigned tally();
		if (results_due.size() != 0) begin
			$display("%0d results never arrived", results_due.size());
			failures += results_due.size();
		end
		return failures;
	endfunction
endclass

module length_prefixed_frame_decoder_unit_tb;

	localparam int TABLE_BYTES = 4 * lpfd_pkg::PARAM_SLOTS;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT_BYTE = 1200;

	typedef enum {
		FR_GOOD,
		FR_EMPTY,
		FR_WRAP_LENGTHS,
		FR_BAD_PREFIX,
		FR_SHORT_PAYLOAD,
		FR_BAD_TABLE,
		FR_NOISE
	} frame_shape_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = '0;
	logic        in_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [3:0]  param_index;
	logic [31:0] param_length;
	logic [1:0]  status;
	logic [31:0] session_word;
	logic [31:0] sequence_word;
	logic [31:0] command_word;
	logic [31:0] ack_word;
	logic [31:0] payload_length;
	logic [31:0] param_total;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	frame_board_t board;

	logic [7:0]  frame_bytes [$];
	int          data_start;
	logic [31:0] frame_sum;
	bit          calm = 1'b0;
	bit          hold_done = 1'b0;
	int          bytes_sent = 0;
	int          quiet_cycles = 0;

	length_prefixed_frame_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.data_byte     (data_byte),
		.param_index   (param_index),
		.param_length  (param_length),
		.status        (status),
		.session_word  (session_word),
		.sequence_word (sequence_word),
		.command_word  (command_word),
		.ack_word      (ack_word),
		.payload_length(payload_length),
		.param_total   (param_total),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: random stalls, one long hold-off once the input has run a while
	always begin
		@(posedge clk);
		if (!hold_done && bytes_sent >= HOLD_AT_BYTE) begin
			out_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_done = 1'b1;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 13);
		end
	end

	// result check and stall count, sampled mid-cycle where signals are settled
	always @(negedge clk) begin
		lpfd_pkg::result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.kind = lpfd_pkg::kind_t'(kind);
			seen.data_byte = data_byte;
			seen.param_index = param_index;
			seen.param_length = param_length;
			seen.status = lpfd_pkg::status_t'(status);
			seen.session_word = session_word;
			seen.sequence_word = sequence_word;
			seen.command_word = command_word;
			seen.ack_word = ack_word;
			seen.payload_length = payload_length;
			seen.param_total = param_total;
			board.check_result(seen);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
	end

	// watchdog
	initial begin
		while (quiet_cycles < STALL_LIMIT) @(negedge clk);
		$display("FAILURE");
		$finish;
	end

	// one input request; returns at the edge that accepts it
	task automatic push_byte(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		board.decode_byte(b, last);
		bytes_sent++;
	endtask

	// let every due result come out, then let the parser settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.waiting() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic await_cfg();
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// write both registers, back to back
	task automatic configure(input bit copy, input logic [31:0] cap);
		cfg_valid <= 1'b1;
		cfg_index <= lpfd_pkg::CFG_COPY_ENABLE;
		cfg_data <= {31'b0, copy};
		await_cfg();
		board.write_register(lpfd_pkg::CFG_COPY_ENABLE, {31'b0, copy});
		cfg_index <= lpfd_pkg::CFG_PAYLOAD_CAPACITY;
		cfg_data <= cap;
		await_cfg();
		board.write_register(lpfd_pkg::CFG_PAYLOAD_CAPACITY, cap);
		cfg_valid <= 1'b0;
	endtask

	function automatic void put_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++) frame_bytes.push_back(w[8*k +: 8]);
	endfunction

	// build one frame of the given shape into frame_bytes
	task automatic compose_frame(input frame_shape_t shape);
		logic [31:0] lens [lpfd_pkg::PARAM_SLOTS];
		logic [31:0] plen;
		logic [31:0] flen;
		logic [31:0] sum;
		int          a;
		int          b;
		frame_bytes.delete();
		sum = '0;
		if (shape == FR_NOISE) begin
			repeat ($urandom_range(1, 60)) frame_bytes.push_back(8'($urandom()));
			data_start = frame_bytes.size();
			frame_sum = '0;
			return;
		end
		foreach (lens[i]) begin
			lens[i] = (shape == FR_EMPTY || $urandom_range(99) < 40) ? 32'd0 :
				32'($urandom_range(1, 6));
		end
		// two huge lengths whose sum wraps to a small value
		if (shape == FR_WRAP_LENGTHS) begin
			a = $urandom_range(lpfd_pkg::PARAM_SLOTS - 1);
			b = (a + 1 + $urandom_range(lpfd_pkg::PARAM_SLOTS - 2)) % lpfd_pkg::PARAM_SLOTS;
			lens[a] = $urandom();
			lens[b] = 32'($urandom_range(0, 8)) - lens[a];
		end
		if (shape == FR_BAD_TABLE) begin
			foreach (lens[i]) lens[i] = $urandom();
		end
		foreach (lens[i]) sum = sum + lens[i];
		plen = 32'(TABLE_BYTES) + sum;
		if (shape == FR_SHORT_PAYLOAD) plen = 32'($urandom_range(0, TABLE_BYTES - 1));
		if (shape == FR_BAD_TABLE) plen = $urandom() | 32'h20;
		flen = plen + 32'(lpfd_pkg::HEADER_BYTES);
		if (shape == FR_BAD_PREFIX) flen = flen ^ ($urandom() | 32'h1);
		put_word(flen);
		repeat (lpfd_pkg::HDR_WORDS - 1) put_word($urandom());
		put_word(plen);
		foreach (lens[i]) put_word(lens[i]);
		data_start = frame_bytes.size();
		frame_sum = sum;
		if (shape == FR_GOOD || shape == FR_EMPTY || shape == FR_WRAP_LENGTHS
				|| shape == FR_BAD_PREFIX) begin
			repeat (sum) frame_bytes.push_back(8'($urandom()));
		end
	endtask

	task automatic send_bytes(input int lo, input int hi, input bit ends_buffer);
		for (int i = lo; i < hi; i++) push_byte(frame_bytes[i], ends_buffer && i == hi - 1);
	endtask

	// optionally cut the frame short, add ignored bytes, close the buffer
	task automatic send_buffer(input int cut_len, input int trailing);
		if (cut_len > 0) begin
			while (frame_bytes.size() > cut_len) void'(frame_bytes.pop_back());
		end
		repeat (trailing) frame_bytes.push_back(8'($urandom()));
		send_bytes(0, frame_bytes.size(), 1'b1);
	endtask

	task automatic random_buffer();
		int           pick;
		int           cut_len;
		int           trailing;
		frame_shape_t shape;
		pick = $urandom_range(99);
		if (pick < 55) shape = FR_GOOD;
		else if (pick < 63) shape = FR_EMPTY;
		else if (pick < 71) shape = FR_WRAP_LENGTHS;
		else if (pick < 77) shape = FR_BAD_PREFIX;
		else if (pick < 83) shape = FR_SHORT_PAYLOAD;
		else if (pick < 89) shape = FR_BAD_TABLE;
		else shape = FR_NOISE;
		compose_frame(shape);
		cut_len = ($urandom_range(99) < 12) ? $urandom_range(1, frame_bytes.size()) : 0;
		trailing = ($urandom_range(99) < 25) ? $urandom_range(1, 6) : 0;
		send_buffer(cut_len, trailing);
	endtask

	initial begin
		int phase_end;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames
		configure(1'b1, lpfd_pkg::CAPACITY_RESET);
		frame_bytes.delete();
		frame_bytes.push_back(8'hA5);
		send_bytes(0, 1, 1'b1);
		compose_frame(FR_GOOD);
		send_buffer(0, 0);
		compose_frame(FR_EMPTY);
		send_buffer(0, 3);
		compose_frame(FR_BAD_PREFIX);
		send_buffer(0, 0);
		compose_frame(FR_SHORT_PAYLOAD);
		send_buffer(0, 0);
		compose_frame(FR_BAD_TABLE);
		send_buffer(0, 2);
		compose_frame(FR_WRAP_LENGTHS);
		send_buffer(0, 0);

		// all-ones header, payload length wraps the frame length
		frame_bytes.delete();
		put_word(32'd19);
		repeat (lpfd_pkg::HDR_WORDS) put_word('1);
		repeat (lpfd_pkg::PARAM_SLOTS) put_word('0);
		send_buffer(0, 0);

		// buffer ends inside the length table
		compose_frame(FR_GOOD);
		send_buffer(data_start - 5, 0);

		// no space: full frame, then one cut inside its data
		wait_drained();
		configure(1'b1, 32'd2);
		do compose_frame(FR_GOOD); while (frame_sum <= 2);
		send_buffer(0, 1);
		do compose_frame(FR_GOOD); while (frame_sum <= 2);
		send_buffer(data_start + 1, 0);

		// copy enable toggled while data bytes flow
		wait_drained();
		configure(1'b1, '1);
		do compose_frame(FR_GOOD); while (frame_sum < 4);
		send_bytes(0, data_start + 2, 1'b0);
		wait_drained();
		configure(1'b0, '1);
		send_bytes(data_start + 2, data_start + 3, 1'b0);
		wait_drained();
		configure(1'b1, '1);
		send_bytes(data_start + 3, frame_bytes.size(), 1'b1);

		// copy disabled
		wait_drained();
		configure(1'b0, '0);
		compose_frame(FR_GOOD);
		send_buffer(0, 0);

		// random buffers under several register settings
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			case (p)
				0: configure(1'b1, lpfd_pkg::CAPACITY_RESET);
				1: configure(1'b0, '0);
				2: configure(1'b1, '0);
				3: configure(1'b1, '1);
				4: configure(1'b1, 32'($urandom_range(0, 40)));
				default: configure(1'b0, $urandom());
			endcase
			calm = (p == 3);
			phase_end = bytes_sent + 150;
			while (bytes_sent < phase_end) random_buffer();
		end
		calm = 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (board.tally() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
